>>> design/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
// No dependencies; every other file of the block but sfd_checker imports this package.
`default_nettype none

package sfd_pkg;

	// Configuration register map (byte address is 4 times the index).
	localparam int unsigned NUM_REGS      = 5;
	localparam int unsigned ADDR_WIDTH    = 5;
	localparam logic [2:0]  REG_MAX_LEN   = 3'd0;
	localparam logic [2:0]  REG_HEAD      = 3'd1;
	localparam logic [2:0]  REG_TAIL      = 3'd2;
	localparam logic [2:0]  REG_COMMAND   = 3'd3;
	localparam logic [2:0]  REG_MIN_LEN   = 3'd4;

	// Reset values of the registers.
	localparam logic [11:0] MAX_LEN_RESET = 12'd1500;
	localparam logic [7:0]  HEAD_RESET    = 8'h7E;
	localparam logic [31:0] TAIL_RESET    = 32'hFFFC_FFFF;
	localparam logic [7:0]  COMMAND_RESET = 8'h01;
	localparam logic [15:0] MIN_LEN_RESET = 16'd5;

	localparam int unsigned INDEX_WIDTH_DEFAULT = 12;
	localparam int unsigned MAX_LEN_WIDTH       = 12;

	// Frame positions of the header fields.
	localparam int unsigned POS_LEN_HI    = 1;
	localparam int unsigned POS_LEN_LO    = 2;
	localparam int unsigned POS_COMMAND   = 3;
	localparam int unsigned POS_SERIAL_HI = 4;
	localparam int unsigned POS_SERIAL_LO = 5;
	// The checksum sum picks up the byte five back once this many bytes are in.
	localparam int unsigned POS_SUM_START = 9;
	// Frames shorter than this carry no checkable header.
	localparam int unsigned MIN_CHECK_LEN = 11;

	typedef struct packed {
		logic [11:0] max_frame_len;
		logic [7:0]  head_byte;
		logic [31:0] tail_word;
		logic [7:0]  command_code;
		logic [15:0] min_length_field;
	} cfg_t;

	typedef struct packed {
		logic frame_end;
		logic overflow;
		logic command_ok;
		logic length_ok;
		logic checksum_ok;
	} flags_t;

endpackage

`default_nettype wire

>>> design/sfd_regs.sv
// APB-style configuration register file of the serial frame deframer.
// Depends on sfd_pkg for the register map and reset values.
`default_nettype none

module sfd_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sfd_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output sfd_pkg::cfg_t                       cfg
);
	import sfd_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[ADDR_WIDTH-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_len    <= MAX_LEN_RESET;
			cfg_q.head_byte        <= HEAD_RESET;
			cfg_q.tail_word        <= TAIL_RESET;
			cfg_q.command_code     <= COMMAND_RESET;
			cfg_q.min_length_field <= MIN_LEN_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MAX_LEN: cfg_q.max_frame_len    <= pwdata[11:0];
				REG_HEAD:    cfg_q.head_byte        <= pwdata[7:0];
				REG_TAIL:    cfg_q.tail_word        <= pwdata;
				REG_COMMAND: cfg_q.command_code     <= pwdata[7:0];
				REG_MIN_LEN: cfg_q.min_length_field <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MAX_LEN: prdata = {20'd0, cfg_q.max_frame_len};
			REG_HEAD:    prdata = {24'd0, cfg_q.head_byte};
			REG_TAIL:    prdata = cfg_q.tail_word;
			REG_COMMAND: prdata = {24'd0, cfg_q.command_code};
			REG_MIN_LEN: prdata = {16'd0, cfg_q.min_length_field};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> design/sfd_core.sv
// Frame tracking state and per-byte result logic of the serial frame deframer.
// Depends on sfd_pkg for the configuration struct, flags and frame positions.
`default_nettype none

module sfd_core #(
	parameter int unsigned INDEX_WIDTH = sfd_pkg::INDEX_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sfd_pkg::cfg_t          cfg,
	input  wire logic                   fire,
	input  wire logic [7:0]             rx_byte,
	output logic                        has_result,
	output logic [INDEX_WIDTH-1:0]      byte_index,
	output logic [INDEX_WIDTH-1:0]      frame_length,
	output logic [15:0]                 serial_number,
	output sfd_pkg::flags_t             flags
);
	import sfd_pkg::*;

	localparam int unsigned LW = (INDEX_WIDTH > MAX_LEN_WIDTH) ? INDEX_WIDTH : MAX_LEN_WIDTH;
	localparam logic [INDEX_WIDTH-1:0] INDEX_MASK = {INDEX_WIDTH{1'b1}};

	logic [INDEX_WIDTH-1:0] position_q, arrival_q;
	logic [31:0]            tail_q;
	logic [7:0]             older_q, sum_q, command_q;
	logic [15:0]            length_q, serial_q;
	logic                   trunc_q;

	logic [INDEX_WIDTH-1:0] position_nx, arrival_nx, limit;
	logic [LW-1:0]          max_ext, mask_ext;
	logic [31:0]            tail_nx;
	logic [7:0]             older_nx, sum_nx, command_nx;
	logic [15:0]            length_nx, serial_nx;
	logic                   trunc_nx, take, stored, done, long_enough;

	always_comb begin
		max_ext  = LW'(cfg.max_frame_len);
		mask_ext = LW'(INDEX_MASK);
		limit    = (max_ext < mask_ext) ? INDEX_WIDTH'(max_ext) : INDEX_MASK;

		take   = (arrival_q != '0) || (rx_byte == cfg.head_byte);
		stored = position_q < limit;

		position_nx = stored ? position_q + 1'b1 : position_q;
		trunc_nx    = trunc_q | ~stored;

		length_nx  = length_q;
		command_nx = command_q;
		serial_nx  = serial_q;
		if (arrival_q == INDEX_WIDTH'(POS_LEN_HI))         length_nx  = {rx_byte, 8'd0};
		else if (arrival_q == INDEX_WIDTH'(POS_LEN_LO))    length_nx  = {length_q[15:8], rx_byte};
		else if (arrival_q == INDEX_WIDTH'(POS_COMMAND))   command_nx = rx_byte;
		else if (arrival_q == INDEX_WIDTH'(POS_SERIAL_HI)) serial_nx  = {rx_byte, 8'd0};
		else if (arrival_q == INDEX_WIDTH'(POS_SERIAL_LO)) serial_nx  = {serial_q[15:8], rx_byte};

		sum_nx     = (arrival_q >= INDEX_WIDTH'(POS_SUM_START)) ? sum_q + older_q : sum_q;
		older_nx   = tail_q[31:24];
		tail_nx    = {tail_q[23:0], rx_byte};
		arrival_nx = (arrival_q != INDEX_MASK) ? arrival_q + 1'b1 : arrival_q;

		done        = tail_nx == cfg.tail_word;
		long_enough = arrival_nx >= INDEX_WIDTH'(MIN_CHECK_LEN);

		has_result        = take && (stored || done);
		byte_index        = stored ? position_q : '0;
		frame_length      = done ? position_nx : '0;
		serial_number     = done ? serial_nx : 16'd0;
		flags.frame_end   = done;
		flags.overflow    = done & trunc_nx;
		flags.command_ok  = done & long_enough & (command_nx == cfg.command_code);
		flags.length_ok   = done & long_enough & (length_nx >= cfg.min_length_field);
		flags.checksum_ok = done & long_enough & (sum_nx == older_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			arrival_q  <= '0;
			tail_q     <= '0;
			older_q    <= '0;
			sum_q      <= '0;
			command_q  <= '0;
			length_q   <= '0;
			serial_q   <= '0;
			trunc_q    <= 1'b0;
		end else if (fire && take) begin
			if (done) begin
				// The tail closed the frame: start over, waiting for a header.
				position_q <= '0;
				arrival_q  <= '0;
				tail_q     <= '0;
				older_q    <= '0;
				sum_q      <= '0;
				command_q  <= '0;
				length_q   <= '0;
				serial_q   <= '0;
				trunc_q    <= 1'b0;
			end else begin
				position_q <= position_nx;
				arrival_q  <= arrival_nx;
				tail_q     <= tail_nx;
				older_q    <= older_nx;
				sum_q      <= sum_nx;
				command_q  <= command_nx;
				length_q   <= length_nx;
				serial_q   <= serial_nx;
				trunc_q    <= trunc_nx;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/serial_frame_deframer.sv
// Top level of the serial frame deframer: input register, frame logic, result register.
// Depends on sfd_pkg, sfd_regs and sfd_core.
`default_nettype none

// The deframer takes one received byte per item and sustains one item per clock
// cycle. An accepted byte sits in an input register; the frame logic then updates
// its running state and, when the byte is stored or closes a frame, writes one
// result item into the output register, from which the result is presented.
// Bytes outside a frame and bytes past max_frame_len that do not close the frame
// produce no item. The input side keeps accepting while a finished result waits
// for out_ready; it stalls only when both the input register and the output
// register are full. The rate is set by the single state update of the frame
// logic per byte. Configuration registers are written through the APB-style port
// and must only change while no item is in flight.
module serial_frame_deframer #(
	parameter int unsigned INDEX_WIDTH = sfd_pkg::INDEX_WIDTH_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sfd_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// Received bytes
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     rx_byte,
	// Result items
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [7:0]                          out_byte,
	output logic [INDEX_WIDTH-1:0]              byte_index,
	output logic                                frame_end,
	output logic [INDEX_WIDTH-1:0]              frame_length,
	output logic                                overflow,
	output logic                                command_ok,
	output logic                                length_ok,
	output logic                                checksum_ok,
	output logic [15:0]                         serial_number
);
	import sfd_pkg::*;

	cfg_t                   cfg;
	flags_t                 core_flags, flags_s2;
	logic                   valid_s1, valid_s2, advance, has_result;
	logic [7:0]             byte_s1, byte_s2;
	logic [INDEX_WIDTH-1:0] core_index, core_length, index_s2, length_s2;
	logic [15:0]            core_serial, serial_s2;

	assign pready = 1'b1;

	sfd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// The byte in the input register is processed once the output register can
	// take whatever result it might produce.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	sfd_core #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.fire         (advance),
		.rx_byte      (byte_s1),
		.has_result   (has_result),
		.byte_index   (core_index),
		.frame_length (core_length),
		.serial_number(core_serial),
		.flags        (core_flags)
	);

	// Output register: loaded with a result, or emptied when its item is taken
	// and nothing new arrives behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= has_result;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			byte_s2   <= byte_s1;
			index_s2  <= core_index;
			length_s2 <= core_length;
			serial_s2 <= core_serial;
			flags_s2  <= core_flags;
		end
	end

	assign out_valid     = valid_s2;
	assign out_byte      = byte_s2;
	assign byte_index    = index_s2;
	assign frame_end     = flags_s2.frame_end;
	assign frame_length  = length_s2;
	assign overflow      = flags_s2.overflow;
	assign command_ok    = flags_s2.command_ok;
	assign length_ok     = flags_s2.length_ok;
	assign checksum_ok   = flags_s2.checksum_ok;
	assign serial_number = serial_s2;

endmodule

`default_nettype wire

>>> design/sfd_checker.sv
// Port-level checks of the serial frame deframer, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module sfd_checker #(
	parameter int unsigned INDEX_WIDTH = 12
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [7:0]             out_byte,
	input wire logic [INDEX_WIDTH-1:0] byte_index,
	input wire logic                   frame_end,
	input wire logic [INDEX_WIDTH-1:0] frame_length,
	input wire logic                   overflow,
	input wire logic                   command_ok,
	input wire logic                   length_ok,
	input wire logic                   checksum_ok,
	input wire logic [15:0]            serial_number
);

	// A result that does not close a frame carries no frame summary.
	a_mid_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> !overflow && !command_ok && !length_ok &&
			!checksum_ok && frame_length == '0 && serial_number == 16'd0)
		else $error("frame summary set on a byte that does not close a frame");

	// Without truncation the closing byte is the last stored one.
	a_length_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && !overflow |->
			frame_length == INDEX_WIDTH'(byte_index + 1'b1))
		else $error("frame length disagrees with the closing byte index");

	// A truncated frame ends with nothing stored past the limit, so its count is zero
	// only if max_frame_len is zero; an untruncated one always stored its bytes.
	a_no_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && frame_length == '0 |-> overflow)
		else $error("empty frame reported without overflow");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(byte_index) && $stable(frame_end))
		else $error("result changed while stalled");

endmodule

bind serial_frame_deframer sfd_checker #(
	.INDEX_WIDTH(INDEX_WIDTH)
) u_sfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.byte_index   (byte_index),
	.frame_end    (frame_end),
	.frame_length (frame_length),
	.overflow     (overflow),
	.command_ok   (command_ok),
	.length_ok    (length_ok),
	.checksum_ok  (checksum_ok),
	.serial_number(serial_number)
);

`default_nettype wire
